[rtl/bffp_pkg.sv]
package bffp_pkg;

  // Fixed geometry of the binary64 input and the packed output word.
  localparam int WORD_BITS = 32;
  localparam int MANT_BITS = 52;
  localparam int EXP_BITS  = 11;
  localparam int EXP_BIAS  = 1023;
  localparam int CFG_BITS  = 12;
  localparam int FILL_BITS = 5;
  localparam int LEN_BITS  = 6;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_GLOBAL_EXP  = 1'b0,
    CFG_SEGMENT_EXP = 1'b1
  } cfg_reg_t;

  // High and low parts of one sample, low word bits only.
  typedef struct packed {
    logic [WORD_BITS-1:0] hi;
    logic [WORD_BITS-1:0] lo;
  } split_t;

  // Outcome of appending one field to the word accumulator.
  typedef struct packed {
    logic [WORD_BITS-1:0] acc;
    logic [FILL_BITS-1:0] fill;
    logic                 emit;
    logic [WORD_BITS-1:0] word;
  } pack_t;

  // Append the low nb bits (1 to 32) of v, MSB first, below the filled bits.
  // The word and the next accumulator are the two halves of a 64-bit window.
  function automatic pack_t pack_bits(input logic [WORD_BITS-1:0] acc,
                                      input logic [FILL_BITS-1:0] fill,
                                      input logic [WORD_BITS-1:0] v,
                                      input logic [LEN_BITS-1:0]  nb);
    logic [WORD_BITS-1:0]   vm;
    logic [LEN_BITS:0]      occ;
    logic [2*WORD_BITS-1:0] win;
    pack_t                  res;
    if (nb >= LEN_BITS'(WORD_BITS)) begin
      vm = v;
    end else begin
      vm = v & ((WORD_BITS'(1) << nb[FILL_BITS-1:0]) - WORD_BITS'(1));
    end
    occ = {2'b00, fill} + {1'b0, nb};
    win = {acc, {WORD_BITS{1'b0}}} |
          ({{WORD_BITS{1'b0}}, vm} << ((LEN_BITS+1)'(2*WORD_BITS) - occ));
    res.word = win[2*WORD_BITS-1:WORD_BITS];
    res.fill = occ[FILL_BITS-1:0];
    if (occ >= (LEN_BITS+1)'(WORD_BITS)) begin
      res.emit = 1'b1;
      res.acc  = win[WORD_BITS-1:0];
    end else begin
      res.emit = 1'b0;
      res.acc  = win[2*WORD_BITS-1:WORD_BITS];
    end
    return res;
  endfunction

endpackage

[rtl/bffp_split.sv]
module bffp_split (
  input  logic [63:0]                      sample_bits,
  input  logic signed [bffp_pkg::CFG_BITS-1:0] global_exp,
  output bffp_pkg::split_t                 split
);
  import bffp_pkg::*;

  logic                       neg;
  logic [EXP_BITS-1:0]        ef;
  logic [MANT_BITS:0]         m;
  logic signed [13:0]         g_ext;
  logic signed [13:0]         sh;
  logic signed [13:0]         r;
  logic [127:0]               wide;
  logic [63:0]                a;
  logic                       guard;
  logic                       sticky;
  logic [62:0]                s;
  logic [WORD_BITS-1:0]       hm;
  logic [WORD_BITS-1:0]       n0;
  logic [WORD_BITS-1:0]       n1;
  logic                       adj;

  // Decode the binary64 fields; exponent field zero means subnormal or zero.
  always_comb begin
    neg   = sample_bits[63];
    ef    = sample_bits[62:MANT_BITS];
    g_ext = {{2{global_exp[CFG_BITS-1]}}, global_exp};
    if (ef != '0) begin
      m  = {1'b1, sample_bits[MANT_BITS-1:0]};
      sh = $signed({3'b000, ef}) - 14'sd1023 - g_ext;
    end else begin
      m  = {1'b0, sample_bits[MANT_BITS-1:0]};
      sh = 14'sd1 - 14'(EXP_BIAS) - g_ext;
    end
  end

  // Align the magnitude to the fixed-point grid, keeping guard and sticky.
  always_comb begin
    r      = -sh;
    wide   = '0;
    a      = '0;
    guard  = 1'b0;
    sticky = 1'b0;
    if (!sh[13]) begin
      if (sh < 14'sd64) begin
        a = {11'd0, m} << sh[5:0];
      end
    end else if (r < 14'sd64) begin
      wide   = {11'd0, m, 64'd0} >> r[5:0];
      a      = wide[127:64];
      guard  = wide[63];
      sticky = |wide[62:0];
    end else begin
      sticky = |m;
    end
  end

  // Round at two to the 31 half away from zero, then round the remainder.
  always_comb begin
    s   = a[62:0] + 63'h4000_0000;
    hm  = s[62:31];
    n0  = {1'b0, s[30:0]} - 32'h4000_0000;
    adj = n0[WORD_BITS-1] ? (guard & sticky) : guard;
    n1  = n0 + {{(WORD_BITS-1){1'b0}}, adj};
    if (neg) begin
      split.hi = -hm;
      split.lo = -n1;
    end else begin
      split.hi = hm;
      split.lo = n1;
    end
  end

endmodule

[rtl/block_float_fixed_bit_packer_unit.sv]
// Channel  | Direction | Transaction contents
// in_      | input     | in_sample_bits (binary64 bits), in_last (segment end)
// out_     | output    | out_packed_word (32-bit word), out_final_word (segment end)
// cfg_     | input     | cfg_index selects global or segment exponent, cfg_wdata
//
// A sample passes an input register, a split register and a result register before its
// first word is valid at the result port. A sample yields zero to three words, and the
// result port drains one word per cycle while out_ready is high.
// Reset is synchronous and active low; it clears the exponents, the word accumulator,
// the fill count and all valid flags. A stalled result port holds the result register,
// and the input register and split register fill before in_ready drops.
module block_float_fixed_bit_packer_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic                            cfg_index,
  input  logic [bffp_pkg::CFG_BITS-1:0]   cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [63:0]                     in_sample_bits,
  input  logic                            in_last,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [bffp_pkg::WORD_BITS-1:0]  out_packed_word,
  output logic                            out_final_word
);
  import bffp_pkg::*;

  logic signed [CFG_BITS-1:0]  gexp_r;
  logic signed [CFG_BITS-1:0]  sexp_r;

  logic                        s1_valid_r;
  logic [63:0]                 s1_bits_r;
  logic                        s1_last_r;

  logic                        s2_valid_r;
  split_t                      s2_split_r;
  logic                        s2_last_r;
  split_t                      split_w;

  logic [WORD_BITS-1:0]        acc_r;
  logic [FILL_BITS-1:0]        fill_r;
  logic [WORD_BITS-1:0]        acc_nxt;
  logic [FILL_BITS-1:0]        fill_nxt;

  logic                        b_valid_r;
  logic [WORD_BITS-1:0]        b_word_r [3];
  logic [1:0]                  b_cnt_r;
  logic [1:0]                  b_idx_r;
  logic                        b_fin_r;
  logic [WORD_BITS-1:0]        words_nxt [3];
  logic [1:0]                  cnt_nxt;
  logic                        fin_nxt;

  logic signed [13:0]          gap;
  logic signed [13:0]          hlen_raw;
  logic signed [13:0]          llen_raw;
  logic                        h_on;
  logic                        l_on;
  logic [LEN_BITS-1:0]         hlen;
  logic [LEN_BITS-1:0]         llen;
  pack_t                       p1;
  pack_t                       p2;
  logic [WORD_BITS-1:0]        acc1;
  logic [FILL_BITS-1:0]        fill1;
  logic [WORD_BITS-1:0]        acc2;
  logic [FILL_BITS-1:0]        fill2;
  logic                        e1;
  logic                        e2;
  logic                        e3;

  logic                        b_last_word;
  logic                        b_free;
  logic                        s2_adv;
  logic                        s2_free;
  logic                        s1_adv;

  // Pipeline flow control: a stage moves when the stage after it frees up.
  always_comb begin
    b_last_word = (b_idx_r == b_cnt_r - 2'd1);
    b_free      = !b_valid_r || (out_ready && b_last_word);
    s2_adv      = s2_valid_r && b_free;
    s2_free     = !s2_valid_r || b_free;
    s1_adv      = s1_valid_r && s2_free;
    in_ready    = !s1_valid_r || s2_free;
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gexp_r <= '0;
      sexp_r <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_GLOBAL_EXP:  gexp_r <= cfg_wdata;
        CFG_SEGMENT_EXP: sexp_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Split of the registered sample into high and low parts.
  bffp_split u_split (
    .sample_bits (s1_bits_r),
    .global_exp  (gexp_r),
    .split       (split_w)
  );

  // Field lengths from the exponent gap.
  always_comb begin
    gap      = {{2{gexp_r[CFG_BITS-1]}}, gexp_r} - {{2{sexp_r[CFG_BITS-1]}}, sexp_r};
    hlen_raw = 14'(MANT_BITS + 3 - 31) - gap;
    llen_raw = 14'(MANT_BITS + 3) - gap;
    h_on     = hlen_raw > 14'sd0;
    l_on     = llen_raw > 14'sd0;
    hlen     = (hlen_raw > 14'(WORD_BITS)) ? LEN_BITS'(WORD_BITS) : hlen_raw[LEN_BITS-1:0];
    llen     = (llen_raw > 14'(WORD_BITS)) ? LEN_BITS'(WORD_BITS) : llen_raw[LEN_BITS-1:0];
  end

  // Pack the high part, then the low part, then flush on the segment end.
  always_comb begin
    p1    = pack_bits(acc_r, fill_r, s2_split_r.hi, hlen);
    e1    = h_on && l_on && p1.emit;
    acc1  = (h_on && l_on) ? p1.acc  : acc_r;
    fill1 = (h_on && l_on) ? p1.fill : fill_r;
    p2    = pack_bits(acc1, fill1, s2_split_r.lo, llen);
    e2    = l_on && p2.emit;
    acc2  = l_on ? p2.acc  : acc1;
    fill2 = l_on ? p2.fill : fill1;
    e3    = s2_last_r && (fill2 != '0);
    if (s2_last_r) begin
      acc_nxt  = '0;
      fill_nxt = '0;
    end else begin
      acc_nxt  = acc2;
      fill_nxt = fill2;
    end
  end

  // Gather the emitted words in order.
  always_comb begin
    cnt_nxt      = 2'd0;
    words_nxt[0] = p1.word;
    words_nxt[1] = p2.word;
    words_nxt[2] = acc2;
    if (e1) begin
      cnt_nxt = 2'd1;
    end
    if (e2) begin
      if (e1) begin
        words_nxt[1] = p2.word;
      end else begin
        words_nxt[0] = p2.word;
      end
      cnt_nxt = cnt_nxt + 2'd1;
    end
    if (e3) begin
      case (cnt_nxt)
        2'd0:    words_nxt[0] = acc2;
        2'd1:    words_nxt[1] = acc2;
        default: words_nxt[2] = acc2;
      endcase
      cnt_nxt = cnt_nxt + 2'd1;
    end
    fin_nxt = s2_last_r && (cnt_nxt != 2'd0);
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
      b_valid_r  <= 1'b0;
      b_idx_r    <= 2'd0;
      acc_r      <= '0;
      fill_r     <= '0;
    end else begin
      if (in_valid && in_ready) begin
        s1_valid_r <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      if (s1_adv) begin
        s2_valid_r <= 1'b1;
      end else if (s2_adv) begin
        s2_valid_r <= 1'b0;
      end

      if (s2_adv) begin
        acc_r  <= acc_nxt;
        fill_r <= fill_nxt;
      end

      if (s2_adv && (cnt_nxt != 2'd0)) begin
        b_valid_r <= 1'b1;
        b_idx_r   <= 2'd0;
      end else if (b_valid_r && out_ready) begin
        if (b_last_word) begin
          b_valid_r <= 1'b0;
        end else begin
          b_idx_r <= b_idx_r + 2'd1;
        end
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_bits_r <= in_sample_bits;
      s1_last_r <= in_last;
    end
    if (s1_adv) begin
      s2_split_r <= split_w;
      s2_last_r  <= s1_last_r;
    end
    if (s2_adv && (cnt_nxt != 2'd0)) begin
      b_word_r <= words_nxt;
      b_cnt_r  <= cnt_nxt;
      b_fin_r  <= fin_nxt;
    end
  end

  // Result port shows one word of the result register per transaction.
  always_comb begin
    out_valid       = b_valid_r;
    out_packed_word = b_word_r[b_idx_r];
    out_final_word  = b_fin_r && b_last_word;
  end

endmodule

[rtl/bffp_checker.sv]
module bffp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_packed_word,
  input logic        out_final_word
);

  // Reset empties the result side.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // With nothing waiting at the result port the pipeline can always take a sample.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled while result side is empty");

  // A stalled result keeps its valid.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped before transaction");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_packed_word) && $stable(out_final_word))
    else $error("result payload changed while stalled");

endmodule

bind block_float_fixed_bit_packer_unit bffp_checker u_bffp_checker (.*);

[sim/tb_block_float_fixed_bit_packer_unit.sv]
`timescale 1ns / 1ps

module tb_block_float_fixed_bit_packer_unit;
  import bffp_pkg::*;

  // Expected packed-word stream for the binary64 block-float packer.
  class packed_word_board;
    typedef struct {
      logic [WORD_BITS-1:0] word;
      logic                 fin;
    } due_t;

    due_t                 words_due[$];
    int                   glob_exp;
    int                   seg_exp;
    logic [WORD_BITS-1:0] acc;
    int                   fill;
    int                   bad_words;

    function new();
      glob_exp  = 0;
      seg_exp   = 0;
      acc       = '0;
      fill      = 0;
      bad_words = 0;
    endfunction

    function void set_exponent(cfg_reg_t idx, logic [CFG_BITS-1:0] val);
      if (idx == CFG_GLOBAL_EXP) begin
        glob_exp = $signed(val);
      end else begin
        seg_exp = $signed(val);
      end
    endfunction

    function int pending();
      return words_due.size();
    endfunction

    // Scale the sample by 2^(52 - global exponent) and split it into the part
    // rounded at 2^31 and the signed remainder, both kept modulo 2^64.
    function void split_scaled(input logic [63:0] bits,
                               output logic [63:0] hi, output logic [63:0] lo);
      logic [63:0] m;
      logic [63:0] a;
      logic [63:0] hm;
      logic [63:0] n;
      logic        guard;
      logic        sticky;
      int          e;
      int          sh;
      int          r;
      m      = {12'd0, bits[51:0]};
      e      = -1074;
      a      = '0;
      guard  = 1'b0;
      sticky = 1'b0;
      if (bits[62:52] != 11'd0) begin
        m[52] = 1'b1;
        e     = bits[62:52];
        e     = e - 1075;
      end
      sh = e + 52 - glob_exp;
      if (sh >= 0) begin
        if (sh < 64) a = m << sh;
      end else begin
        r = -sh;
        if (r < 64) begin
          a      = m >> r;
          guard  = m[r-1];
          sticky = (m & ((64'd1 << (r - 1)) - 64'd1)) != 64'd0;
        end else begin
          sticky = (m != 64'd0);
        end
      end
      // The fraction below a is one half when guard is set; sticky says more.
      hm = (a + (64'd1 << 30)) >> 31;
      n  = a - (hm << 31);
      if (n[63]) begin
        n = n + (guard & sticky);
      end else begin
        n = n + guard;
      end
      if (bits[63]) begin
        hm = -hm;
        n  = -n;
      end
      hi = hm;
      lo = n;
    endfunction

    // Append the low nb bits of v below the filled bits, top first.
    function void append_field(logic [63:0] v, int nb);
      int   occ;
      int   rem;
      due_t full;
      v   = v & ((64'd1 << nb) - 64'd1);
      occ = fill + nb;
      if (occ >= WORD_BITS) begin
        rem       = occ - WORD_BITS;
        full.word = acc | WORD_BITS'(v >> rem);
        full.fin  = 1'b0;
        words_due.push_back(full);
        acc = '0;
        v   = v & ((64'd1 << rem) - 64'd1);
        occ = rem;
      end
      acc  = acc | WORD_BITS'(v << (WORD_BITS - occ));
      fill = occ;
    endfunction

    // Note one accepted input transaction and queue the words it causes.
    function void note_sample(logic [63:0] bits, logic last);
      int          gap;
      int          hlen;
      int          llen;
      int          start_cnt;
      logic [63:0] hi;
      logic [63:0] lo;
      due_t        tail;
      start_cnt = words_due.size();
      gap  = glob_exp - seg_exp;
      hlen = MANT_BITS + 3 - 31 - gap;
      llen = MANT_BITS + 3 - gap;
      if (hlen > WORD_BITS) hlen = WORD_BITS;
      if (llen > WORD_BITS) llen = WORD_BITS;
      if (llen > 0) begin
        split_scaled(bits, hi, lo);
        if (hlen > 0) append_field(hi, hlen);
        append_field(lo, llen);
      end
      // The segment end flushes a partial word and flags the step's last word.
      if (last) begin
        if (fill != 0) begin
          tail.word = acc;
          tail.fin  = 1'b0;
          words_due.push_back(tail);
        end
        acc  = '0;
        fill = 0;
        if (words_due.size() > start_cnt) begin
          tail     = words_due.pop_back();
          tail.fin = 1'b1;
          words_due.push_back(tail);
        end
      end
    endfunction

    // Compare one accepted result transaction with the oldest expected word.
    function void check_word(logic [WORD_BITS-1:0] word, logic fin);
      due_t want;
      if (words_due.size() == 0) begin
        bad_words++;
        if (bad_words <= 10)
          $display("unexpected word %h final %b", word, fin);
      end else begin
        want = words_due.pop_front();
        if (want.word !== word || want.fin !== fin) begin
          bad_words++;
          if (bad_words <= 10)
            $display("mismatch: expected word %h final %b, got word %h final %b",
                     want.word, want.fin, word, fin);
        end
      end
    endfunction
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_we = 1'b0;
  logic                 cfg_index = CFG_GLOBAL_EXP;
  logic [CFG_BITS-1:0]  cfg_wdata = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [63:0]          in_sample_bits = '0;
  logic                 in_last = 1'b0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [WORD_BITS-1:0] out_packed_word;
  logic                 out_final_word;

  packed_word_board board;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   g_cur = 0;
  logic hold_req = 1'b0;
  logic hold_seen = 1'b0;
  int   hold_left = 0;
  int   phase_gap [8] = '{0, 1, 24, 25, 54, -3, 13, 40};

  block_float_fixed_bit_packer_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample_bits  (in_sample_bits),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_packed_word (out_packed_word),
    .out_final_word  (out_final_word)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 300;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= (int'($urandom_range(99)) >= recv_stall_pct);
    end
  end

  // Every accepted result transaction goes to the board.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      board.check_word(out_packed_word, out_final_word);
  end

  // A sample near the scale of exponent g most of the time, with specials,
  // exact rounding halves and fully random patterns mixed in.
  function automatic logic [63:0] pick_sample(input int g);
    logic [63:0] raw;
    logic [51:0] frac;
    int          kind;
    int          ef;
    int          k;
    raw  = {$urandom, $urandom};
    frac = raw[51:0];
    kind = $urandom_range(99);
    if (kind < 15) return raw;
    if (kind < 25) begin
      case ($urandom_range(4))
        0:       return {raw[63], 63'd0};
        1:       return {raw[63], 11'h7FF, 52'd0};
        2:       return {raw[63], 11'h7FF, frac};
        3:       return {raw[63], 11'h000, frac};
        default: return {raw[63], 11'h7FE, frac};
      endcase
    end
    ef = g + 1023 + int'($urandom_range(70)) - 62;
    if (ef < 0) ef = 0;
    if (ef > 2047) ef = 2047;
    if ($urandom_range(2) == 0) begin
      k    = $urandom_range(52, 1);
      frac = ((frac >> k) << k) | (52'd1 << (k - 1));
    end
    return {raw[63], 11'(ef), frac};
  endfunction

  // Offer one sample and wait until the block takes the transaction.
  task automatic send_sample(input logic [63:0] bits, input logic last);
    while (int'($urandom_range(99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_sample_bits <= bits;
    in_last        <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.note_sample(bits, last);
  endtask

  task automatic pause_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
  endtask

  // Samples that cause no word may still be in the pipeline, so let them drain
  // before touching the exponents.
  task automatic set_exponents(input int g, input int s);
    pause_until_drained();
    repeat (8) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_GLOBAL_EXP;
    cfg_wdata <= CFG_BITS'(g);
    @(posedge clk);
    cfg_index <= CFG_SEGMENT_EXP;
    cfg_wdata <= CFG_BITS'(s);
    @(posedge clk);
    cfg_we <= 1'b0;
    board.set_exponent(CFG_GLOBAL_EXP, CFG_BITS'(g));
    board.set_exponent(CFG_SEGMENT_EXP, CFG_BITS'(s));
    g_cur = g;
  endtask

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int g;
    int s;
    int mode;
    board = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Reset exponents: zeros, infinities, NaN, subnormal limits, rounding halves.
    send_sample(64'h0000_0000_0000_0000, 1'b0);
    send_sample(64'h8000_0000_0000_0000, 1'b0);
    send_sample(64'h7FF0_0000_0000_0000, 1'b0);
    send_sample(64'hFFF0_0000_0000_0000, 1'b0);
    send_sample(64'h7FF8_0000_0000_0001, 1'b1);
    send_sample(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_sample(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    send_sample(64'h0000_0000_0000_0001, 1'b0);
    send_sample(64'h000F_FFFF_FFFF_FFFF, 1'b0);
    send_sample(64'h3FF0_0000_0000_0000, 1'b1);
    send_sample(64'hBFF0_0000_0000_0000, 1'b0);
    send_sample(64'h3CA0_0000_0000_0000, 1'b0);
    send_sample(64'hBCA0_0000_0000_0000, 1'b0);
    send_sample(64'h3E90_0000_0000_0000, 1'b0);
    send_sample(64'hBE90_0000_0000_0000, 1'b0);
    send_sample(64'h3CA8_0000_0000_0000, 1'b0);

    // Gap of 55 packs nothing; the first end flushes the partial word left
    // above, the second has no word to flag.
    set_exponents(1024, 969);
    send_sample(64'h3FF8_0000_0000_0000, 1'b1);
    send_sample(64'h4000_0000_0000_0000, 1'b1);

    // Most negative gap: both field lengths saturate at a full word.
    set_exponents(-1023, 1024);
    send_sample(64'h0000_0000_0000_0001, 1'b0);
    send_sample(64'h3FF0_0000_0000_0000, 1'b0);
    send_sample(64'h8010_0000_0000_0003, 1'b1);

    set_exponents(1024, 1024);
    send_sample(64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
    send_sample(64'hFFF0_0000_0000_0000, 1'b1);

    // Random phases, each with its own exponents and idling pattern.
    for (int p = 0; p < 8; p++) begin
      if (p == 1) begin
        g = 1024;
      end else if (p == 2) begin
        g = -1023;
      end else begin
        g = int'($urandom_range(2047)) - 1023;
      end
      s = g - phase_gap[p];
      if (s < -1023) s = -1023;
      if (s > 1024) s = 1024;
      set_exponents(g, s);
      mode = p % 4;
      send_idle_pct  = (mode == 1) ? 61 : (mode == 3) ? 13 : 0;
      recv_stall_pct = (mode == 2) ? 61 : (mode == 3) ? 13 : 0;
      for (int i = 0; i < 60; i++) begin
        if (p == 0 && i == 10) hold_req <= ~hold_req;
        if (p == 4 && i == 30) pause_until_drained();
        send_sample(pick_sample(g_cur), $urandom_range(7) == 0);
      end
    end

    pause_until_drained();
    repeat (10) @(posedge clk);
    if (board.bad_words == 0 && board.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
